@@ design/fbfa_pkg.sv @@
`default_nettype none
package fbfa_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int WORD_BYTES = 8;
	localparam int MIN_BYTES  = 8;
	localparam int MAX_BYTES  = 4096;

	localparam int IDX_W   = 10;
	localparam int CNT_W   = 11;
	localparam int BYTES_W = 13;
	localparam int OFF_W   = 22;
	localparam int PROD_W  = IDX_W + BYTES_W;
	localparam int ADDR_W  = $clog2(MAX_BLOCKS);
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [CNT_W-1:0]   RESET_COUNT = CNT_W'(1024);
	localparam logic [BYTES_W-1:0] RESET_BYTES = BYTES_W'(8);

	localparam logic REG_BLOCK_COUNT = 1'b0;
	localparam logic REG_BLOCK_BYTES = 1'b1;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_GET  = 2'd1,
		CMD_FREE = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load_item;
		logic commit;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

@@ design/fbfa_ctrl.sv @@
`default_nettype none
module fbfa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output fbfa_pkg::ctrl_cmd_t      cmd
);

	fbfa_pkg::state_t state_q, state_nxt;
	logic             rsp_valid_q, rsp_valid_nxt;
	logic             accept;
	logic             commit;

	assign accept = req_valid && (state_q == fbfa_pkg::S_IDLE);
	// result register is free when empty or being drained this cycle
	assign commit = (state_q == fbfa_pkg::S_EXEC) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fbfa_pkg::S_IDLE: begin
				if (accept) state_nxt = fbfa_pkg::S_EXEC;
			end
			fbfa_pkg::S_EXEC: begin
				if (commit) state_nxt = fbfa_pkg::S_IDLE;
			end
			default: state_nxt = fbfa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall     = (state_q != fbfa_pkg::S_IDLE);
		cmd.load_item = accept;
		cmd.commit    = commit;
		rsp_valid_nxt = rsp_valid_q;
		if (commit) rsp_valid_nxt = 1'b1;
		else if (rsp_valid_q && !rsp_stall) rsp_valid_nxt = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbfa_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= rsp_valid_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

@@ design/fbfa_dp.sv @@
`default_nettype none
module fbfa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fbfa_pkg::ctrl_cmd_t           cmd,
	input  wire logic [fbfa_pkg::CNT_W-1:0]    block_count,
	input  wire logic [fbfa_pkg::BYTES_W-1:0]  block_bytes,
	input  wire logic [1:0]                    command,
	input  wire logic [fbfa_pkg::IDX_W-1:0]    block_index,
	output logic [fbfa_pkg::IDX_W-1:0]         granted_index,
	output logic [fbfa_pkg::OFF_W-1:0]         byte_offset,
	output logic [fbfa_pkg::CNT_W-1:0]         free_count,
	output logic [1:0]                         status
);

	localparam int IW = fbfa_pkg::IDX_W;
	localparam int CW = fbfa_pkg::CNT_W;
	localparam int BW = fbfa_pkg::BYTES_W;
	localparam int PW = fbfa_pkg::PROD_W;

	logic [IW-1:0] link_mem [fbfa_pkg::MAX_BLOCKS];

	// item and link read
	logic [1:0]    cmd_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] link_rd_q;

	// allocator state
	logic [IW-1:0] head_q, head_nxt;
	logic [CW-1:0] flen_q, flen_nxt;
	logic [CW-1:0] fresh_q, fresh_nxt;
	logic [CW-1:0] free_q, free_nxt;
	logic          do_free;

	// result register
	logic [IW-1:0]            granted_q;
	logic [fbfa_pkg::OFF_W-1:0] offset_q;
	logic [CW-1:0]            free_cnt_q;
	fbfa_pkg::status_t        status_q;

	logic [IW-1:0]     granted_nxt;
	fbfa_pkg::status_t status_nxt;
	logic              have;
	logic [CW-1:0]     count_eff;
	logic [BW-1:0]     bytes_clamp;
	logic [BW:0]       bytes_up;
	logic [BW-1:0]     bytes_eff;
	logic [PW-1:0]     product;

	always_comb begin
		if (block_count == '0) count_eff = CW'(1);
		else if (block_count > CW'(fbfa_pkg::MAX_BLOCKS)) count_eff = CW'(fbfa_pkg::MAX_BLOCKS);
		else count_eff = block_count;

		if (block_bytes < BW'(fbfa_pkg::MIN_BYTES)) bytes_clamp = BW'(fbfa_pkg::MIN_BYTES);
		else if (block_bytes > BW'(fbfa_pkg::MAX_BYTES)) bytes_clamp = BW'(fbfa_pkg::MAX_BYTES);
		else bytes_clamp = block_bytes;
		bytes_up  = ({1'b0, bytes_clamp} + (BW+1)'(fbfa_pkg::WORD_BYTES - 1))
			/ (BW+1)'(fbfa_pkg::WORD_BYTES);
		bytes_eff = BW'(bytes_up * (BW+1)'(fbfa_pkg::WORD_BYTES));
	end

	always_comb begin
		head_nxt    = head_q;
		flen_nxt    = flen_q;
		fresh_nxt   = fresh_q;
		free_nxt    = free_q;
		granted_nxt = '0;
		status_nxt  = fbfa_pkg::ST_OK;
		have        = 1'b0;
		do_free     = 1'b0;
		unique case (cmd_q)
			fbfa_pkg::CMD_INIT: begin
				head_nxt  = '0;
				flen_nxt  = '0;
				fresh_nxt = '0;
				free_nxt  = count_eff;
			end
			fbfa_pkg::CMD_GET: begin
				priority if (free_q == '0) begin
					status_nxt = fbfa_pkg::ST_EMPTY;
				end else if (flen_q != '0) begin
					granted_nxt = head_q;
					head_nxt    = link_rd_q;
					flen_nxt    = flen_q - CW'(1);
					free_nxt    = free_q - CW'(1);
					have        = 1'b1;
				end else if (fresh_q < count_eff) begin
					granted_nxt = fresh_q[IW-1:0];
					fresh_nxt   = fresh_q + CW'(1);
					free_nxt    = free_q - CW'(1);
					have        = 1'b1;
				end else begin
					status_nxt = fbfa_pkg::ST_EMPTY;
				end
			end
			fbfa_pkg::CMD_FREE: begin
				if (free_q >= count_eff || {1'b0, idx_q} >= count_eff) begin
					status_nxt = fbfa_pkg::ST_BAD_FREE;
				end else begin
					do_free  = 1'b1;
					head_nxt = idx_q;
					flen_nxt = flen_q + CW'(1);
					free_nxt = free_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign product = PW'(granted_nxt) * PW'(bytes_eff);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q     <= command;
			idx_q     <= block_index;
			link_rd_q <= link_mem[head_q];
		end
		if (cmd.commit && do_free) link_mem[idx_q] <= head_q;
		if (cmd.commit) begin
			granted_q  <= granted_nxt;
			offset_q   <= have ? product[fbfa_pkg::OFF_W-1:0] : '0;
			free_cnt_q <= free_nxt;
			status_q   <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			flen_q  <= '0;
			fresh_q <= '0;
			free_q  <= fbfa_pkg::RESET_COUNT;
		end else if (cmd.commit) begin
			head_q  <= head_nxt;
			flen_q  <= flen_nxt;
			fresh_q <= fresh_nxt;
			free_q  <= free_nxt;
		end
	end

	assign granted_index = granted_q;
	assign byte_offset   = offset_q;
	assign free_count    = free_cnt_q;
	assign status        = status_q;

endmodule
`default_nettype wire

@@ design/fixed_block_free_list_allocator_top.sv @@
// An accepted item goes to the item registers, then to the result register,
// which sets rsp_valid; that write waits while an unread result is stalled.
// No new item is taken until the last is written; the next free-list head
// comes from a registered read of the link memory, made as the item is taken.
// Reset: free count 1024, freed chain and fresh counter empty, registers at
// block_count 1024 and block_bytes 8; the link memory is not cleared.
`default_nettype none
module fixed_block_free_list_allocator_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [fbfa_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [fbfa_pkg::DATA_W-1:0]        pwdata,
	output logic [fbfa_pkg::DATA_W-1:0]             prdata,
	output logic                                    pready,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic [1:0]                         command,
	input  wire logic [fbfa_pkg::IDX_W-1:0]         block_index,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic [fbfa_pkg::IDX_W-1:0]              granted_index,
	output logic [fbfa_pkg::OFF_W-1:0]              byte_offset,
	output logic [fbfa_pkg::CNT_W-1:0]              free_count,
	output logic [1:0]                              status
);

	logic [fbfa_pkg::CNT_W-1:0]   block_count_q;
	logic [fbfa_pkg::BYTES_W-1:0] block_bytes_q;
	logic                         wr_en;
	fbfa_pkg::ctrl_cmd_t          cmd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= fbfa_pkg::RESET_COUNT;
			block_bytes_q <= fbfa_pkg::RESET_BYTES;
		end else if (wr_en) begin
			unique case (paddr[2])
				fbfa_pkg::REG_BLOCK_COUNT: block_count_q <= pwdata[fbfa_pkg::CNT_W-1:0];
				fbfa_pkg::REG_BLOCK_BYTES: block_bytes_q <= pwdata[fbfa_pkg::BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fbfa_pkg::REG_BLOCK_COUNT: prdata = fbfa_pkg::DATA_W'(block_count_q);
			fbfa_pkg::REG_BLOCK_BYTES: prdata = fbfa_pkg::DATA_W'(block_bytes_q);
			default:                   prdata = '0;
		endcase
	end

	fbfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	fbfa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.block_count   (block_count_q),
		.block_bytes   (block_bytes_q),
		.command       (command),
		.block_index   (block_index),
		.granted_index (granted_index),
		.byte_offset   (byte_offset),
		.free_count    (free_count),
		.status        (status)
	);

endmodule
`default_nettype wire
